>>> src/tcpq_pkg.sv
// Shared types, constants and helper functions of the three-class priority queue.
`timescale 1ns / 1ps

package tcpq_pkg;

  // Entries each class can hold.
  localparam int CLASS_DEPTH = 64;
  localparam int NUM_CLASSES = 3;
  localparam int STORE_DEPTH = NUM_CLASSES * CLASS_DEPTH;

  // Field widths.
  localparam int REQ_W    = 2;
  localparam int DATE_W   = 27;
  localparam int CODE_W   = 16;
  localparam int CLASS_W  = 2;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 8;
  localparam int ENTRY_W  = DATE_W + CODE_W;

  // Derived storage widths.
  localparam int PTR_W  = $clog2(CLASS_DEPTH);
  localparam int CNT_W  = $clog2(CLASS_DEPTH + 1);
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int SUM_W  = CNT_W + 2;

  // Class codes carried on the entry_class field.
  localparam logic [CLASS_W-1:0] ENTRY_CLASS_TOP = 2'd3;
  localparam logic [CLASS_W-1:0] ENTRY_CLASS_MID = 2'd2;

  // Internal class slots: ordinary, middle, top.
  localparam logic [1:0] SLOT_ORD = 2'd0;
  localparam logic [1:0] SLOT_MID = 2'd1;
  localparam logic [1:0] SLOT_TOP = 2'd2;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT      = 2'd0,
    REQ_READ_HEAD   = 2'd1,
    REQ_REMOVE_HEAD = 2'd2,
    REQ_REMOVE_TAIL = 2'd3
  } req_type_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_RESULT
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load_out;
  } cmd_t;

  // Advance a class pointer with wrap.
  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(CLASS_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Step a class pointer back with wrap.
  function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(CLASS_DEPTH - 1) : p - 1'b1;
  endfunction

  // First store address of a class region.
  function automatic logic [ADDR_W-1:0] class_base(input logic [1:0] slot);
    logic [ADDR_W-1:0] base;
    base = '0;
    if (slot == SLOT_MID) begin
      base = ADDR_W'(CLASS_DEPTH);
    end else if (slot == SLOT_TOP) begin
      base = ADDR_W'(2 * CLASS_DEPTH);
    end
    return base;
  endfunction

endpackage

>>> src/tcpq_ctrl.sv
// Controller state machine: request acceptance and result handoff.
`timescale 1ns / 1ps

module tcpq_ctrl
  import tcpq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt    = state_r;
    cmd.accept   = 1'b0;
    cmd.load_out = 1'b0;
    in_stall     = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        // The result moves out once the output register is free or drains now.
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The output register fills on a load and empties when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_then_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == S_RESULT) && !cmd.accept)
    else $error("accepted request did not move to the result state");

  a_free_output_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESULT) && !out_valid_r |-> cmd.load_out)
    else $error("result held back from an empty output register");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

>>> src/tcpq_datapath.sv
// Datapath: class pointers and counts, entry store and result register.
`timescale 1ns / 1ps

module tcpq_datapath
  import tcpq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  input  logic [REQ_W-1:0]    in_req_type,
  input  logic [DATE_W-1:0]   in_entry_date,
  input  logic [CODE_W-1:0]   in_entry_code,
  input  logic [CLASS_W-1:0]  in_entry_class,
  output logic [STATUS_W-1:0] out_status,
  output logic [DATE_W-1:0]   out_item_date,
  output logic [CODE_W-1:0]   out_item_code,
  output logic [CLASS_W-1:0]  out_item_class,
  output logic [TOTAL_W-1:0]  out_total_length
);

  // Per-class state.
  logic [CNT_W-1:0] cnt_r [NUM_CLASSES];
  logic [CNT_W-1:0] cnt_nxt [NUM_CLASSES];
  logic [PTR_W-1:0] rp_r [NUM_CLASSES];
  logic [PTR_W-1:0] rp_nxt [NUM_CLASSES];
  logic [PTR_W-1:0] wp_r [NUM_CLASSES];
  logic [PTR_W-1:0] wp_nxt [NUM_CLASSES];

  // Entry store, one region per class.
  logic [ENTRY_W-1:0] store_mem [STORE_DEPTH];
  logic [ENTRY_W-1:0] rdata_r;

  // Request results waiting for the output register.
  status_t           status_r;
  logic              has_item_r;
  logic [CLASS_W-1:0] cls_r;

  // Output register.
  logic [STATUS_W-1:0] out_status_r;
  logic [DATE_W-1:0]   out_date_r;
  logic [CODE_W-1:0]   out_code_r;
  logic [CLASS_W-1:0]  out_class_r;
  logic [TOTAL_W-1:0]  out_total_r;

  req_type_t         req;
  logic [2:0]        nonempty;
  logic              any_held;
  logic [1:0]        ins_slot;
  logic [1:0]        head_slot;
  logic [1:0]        tail_slot;
  logic [1:0]        sel_slot;
  logic              is_insert;
  logic              sel_full;
  logic              has_item;
  logic              wr_en;
  logic              rd_en;
  logic [PTR_W-1:0]  slot_ptr;
  logic [ADDR_W-1:0] addr;
  status_t           status;
  logic [SUM_W-1:0]  held_sum;

  assign req       = req_type_t'(in_req_type);
  assign is_insert = (req == REQ_INSERT);

  always_comb begin
    for (int i = 0; i < NUM_CLASSES; i++) begin
      nonempty[i] = (cnt_r[i] != '0);
    end
  end
  assign any_held = |nonempty;

  // Class chosen by the entry's class code.
  always_comb begin
    priority if (in_entry_class == ENTRY_CLASS_TOP) begin
      ins_slot = SLOT_TOP;
    end else if (in_entry_class == ENTRY_CLASS_MID) begin
      ins_slot = SLOT_MID;
    end else begin
      ins_slot = SLOT_ORD;
    end
  end

  // Head is the highest non-empty class, tail the lowest.
  always_comb begin
    priority if (nonempty[SLOT_TOP]) begin
      head_slot = SLOT_TOP;
    end else if (nonempty[SLOT_MID]) begin
      head_slot = SLOT_MID;
    end else begin
      head_slot = SLOT_ORD;
    end
    priority if (nonempty[SLOT_ORD]) begin
      tail_slot = SLOT_ORD;
    end else if (nonempty[SLOT_MID]) begin
      tail_slot = SLOT_MID;
    end else begin
      tail_slot = SLOT_TOP;
    end
  end

  // Class and store position of the request.
  always_comb begin
    unique case (req)
      REQ_INSERT:      sel_slot = ins_slot;
      REQ_REMOVE_TAIL: sel_slot = tail_slot;
      default:         sel_slot = head_slot;
    endcase
    unique case (req)
      REQ_INSERT:      slot_ptr = wp_r[sel_slot];
      REQ_REMOVE_TAIL: slot_ptr = ptr_prev(wp_r[sel_slot]);
      default:         slot_ptr = rp_r[sel_slot];
    endcase
  end

  assign sel_full = (cnt_r[sel_slot] == CNT_W'(CLASS_DEPTH));
  assign addr     = class_base(sel_slot) + ADDR_W'(slot_ptr);
  assign has_item = !is_insert && any_held;
  assign wr_en    = cmd.accept && is_insert && !sel_full;
  assign rd_en    = cmd.accept && has_item;

  always_comb begin
    if (is_insert) begin
      status = sel_full ? ST_FULL : ST_DONE;
    end else begin
      status = any_held ? ST_DONE : ST_EMPTY;
    end
  end

  // Pointer and count updates for the selected class.
  always_comb begin
    for (int i = 0; i < NUM_CLASSES; i++) begin
      cnt_nxt[i] = cnt_r[i];
      rp_nxt[i]  = rp_r[i];
      wp_nxt[i]  = wp_r[i];
      if (sel_slot == 2'(i)) begin
        if (wr_en) begin
          wp_nxt[i]  = ptr_next(slot_ptr);
          cnt_nxt[i] = cnt_r[i] + 1'b1;
        end else if (rd_en && req == REQ_REMOVE_HEAD) begin
          rp_nxt[i]  = ptr_next(slot_ptr);
          cnt_nxt[i] = cnt_r[i] - 1'b1;
        end else if (rd_en && req == REQ_REMOVE_TAIL) begin
          wp_nxt[i]  = slot_ptr;
          cnt_nxt[i] = cnt_r[i] - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        cnt_r[i] <= '0;
        rp_r[i]  <= '0;
        wp_r[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        cnt_r[i] <= cnt_nxt[i];
        rp_r[i]  <= rp_nxt[i];
        wp_r[i]  <= wp_nxt[i];
      end
    end
  end

  // Entry store: one write or one registered read per request.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[addr] <= {in_entry_date, in_entry_code};
    end
    if (rd_en) begin
      rdata_r <= store_mem[addr];
    end
  end

  // Capture the outcome of the accepted request.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      status_r   <= status;
      has_item_r <= has_item;
      cls_r      <= sel_slot + 2'd1;
    end
  end

  assign held_sum = SUM_W'(cnt_r[SLOT_ORD]) + SUM_W'(cnt_r[SLOT_MID])
                  + SUM_W'(cnt_r[SLOT_TOP]);

  // Output register; item fields are zero when nothing was read.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= status_r;
      out_date_r   <= has_item_r ? rdata_r[ENTRY_W-1:CODE_W] : '0;
      out_code_r   <= has_item_r ? rdata_r[CODE_W-1:0] : '0;
      out_class_r  <= has_item_r ? cls_r : '0;
      out_total_r  <= TOTAL_W'(held_sum);
    end
  end

  assign out_status       = out_status_r;
  assign out_item_date    = out_date_r;
  assign out_item_code    = out_code_r;
  assign out_item_class   = out_class_r;
  assign out_total_length = out_total_r;

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r[SLOT_ORD] <= CNT_W'(CLASS_DEPTH)) && (cnt_r[SLOT_MID] <= CNT_W'(CLASS_DEPTH))
    && (cnt_r[SLOT_TOP] <= CNT_W'(CLASS_DEPTH)))
    else $error("class count beyond class depth");

  a_full_insert_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && is_insert && sel_full |=> $stable(held_sum))
    else $error("insert into a full class changed the queue length");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en && (req != REQ_READ_HEAD) |=> (held_sum == $past(held_sum) - 1'b1))
    else $error("removal did not shrink the queue by one");

endmodule

>>> src/three_class_priority_queue_core.sv
// Top level of the three-class priority queue: controller and datapath joined.
// An accepted request moves the controller to its result state, which loads the result
// into the output register once that register is empty or being taken; it waits there
// while the result side stalls. in_stall stays high from acceptance until that load, so
// no new request is taken before the last result has moved to the output register.
// Reset: synchronous active-low rst_n empties all three classes at once; the entry
// store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module three_class_priority_queue_core
  import tcpq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [REQ_W-1:0]    in_req_type,
  input  logic [DATE_W-1:0]   in_entry_date,
  input  logic [CODE_W-1:0]   in_entry_code,
  input  logic [CLASS_W-1:0]  in_entry_class,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [DATE_W-1:0]   out_item_date,
  output logic [CODE_W-1:0]   out_item_code,
  output logic [CLASS_W-1:0]  out_item_class,
  output logic [TOTAL_W-1:0]  out_total_length
);

  cmd_t cmd;

  // Request sequencing.
  tcpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Queue state and entry store.
  tcpq_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_req_type      (in_req_type),
    .in_entry_date    (in_entry_date),
    .in_entry_code    (in_entry_code),
    .in_entry_class   (in_entry_class),
    .out_status       (out_status),
    .out_item_date    (out_item_date),
    .out_item_code    (out_item_code),
    .out_item_class   (out_item_class),
    .out_total_length (out_total_length)
  );

endmodule

>>> tb/sv/queue_result_checker.sv
// Checker for the three-class priority queue: predicts each result and compares it.
`timescale 1ns / 1ps

module queue_result_checker
  import tcpq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [REQ_W-1:0]    in_req_type,
  input  logic [DATE_W-1:0]   in_entry_date,
  input  logic [CODE_W-1:0]   in_entry_code,
  input  logic [CLASS_W-1:0]  in_entry_class,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [STATUS_W-1:0] out_status,
  input  logic [DATE_W-1:0]   out_item_date,
  input  logic [CODE_W-1:0]   out_item_code,
  input  logic [CLASS_W-1:0]  out_item_class,
  input  logic [TOTAL_W-1:0]  out_total_length,
  output int                  fail_count,
  output int                  pending
);

  typedef struct packed {
    status_t              status;
    logic [DATE_W-1:0]    item_date;
    logic [CODE_W-1:0]    item_code;
    logic [CLASS_W-1:0]   item_class;
    logic [TOTAL_W-1:0]   total_length;
  } queue_result_t;

  // Shadow copy of the queue: one FIFO region per class slot.
  logic [DATE_W-1:0] shadow_date[NUM_CLASSES][CLASS_DEPTH];
  logic [CODE_W-1:0] shadow_code[NUM_CLASSES][CLASS_DEPTH];
  int                oldest_slot[NUM_CLASSES];
  int                free_slot[NUM_CLASSES];
  int                class_fill[NUM_CLASSES];

  queue_result_t     awaited_results[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Apply one request to the shadow queue and return the result it should produce.
  function automatic queue_result_t serve_request(input req_type_t kind,
                                                  input logic [DATE_W-1:0] date,
                                                  input logic [CODE_W-1:0] code,
                                                  input logic [CLASS_W-1:0] cls);
    queue_result_t res;
    int slot;
    int pos;
    res = '0;
    res.status = ST_DONE;
    if (kind == REQ_INSERT) begin
      if (cls == ENTRY_CLASS_TOP) begin
        slot = int'(SLOT_TOP);
      end else if (cls == ENTRY_CLASS_MID) begin
        slot = int'(SLOT_MID);
      end else begin
        slot = int'(SLOT_ORD);
      end
      if (class_fill[slot] >= CLASS_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        shadow_date[slot][free_slot[slot]] = date;
        shadow_code[slot][free_slot[slot]] = code;
        free_slot[slot] = (free_slot[slot] + 1) % CLASS_DEPTH;
        class_fill[slot]++;
      end
    end else begin
      // The tail lives in the lowest busy class, the head in the highest.
      slot = -1;
      for (int s = 0; s < NUM_CLASSES; s++) begin
        if (class_fill[s] != 0 && (kind != REQ_REMOVE_TAIL || slot < 0)) begin
          slot = s;
        end
      end
      if (slot < 0) begin
        res.status = ST_EMPTY;
      end else begin
        if (kind == REQ_REMOVE_TAIL) begin
          pos = (free_slot[slot] + CLASS_DEPTH - 1) % CLASS_DEPTH;
        end else begin
          pos = oldest_slot[slot];
        end
        res.item_date  = shadow_date[slot][pos];
        res.item_code  = shadow_code[slot][pos];
        res.item_class = CLASS_W'(slot + 1);
        if (kind == REQ_REMOVE_HEAD) begin
          oldest_slot[slot] = (pos + 1) % CLASS_DEPTH;
          class_fill[slot]--;
        end else if (kind == REQ_REMOVE_TAIL) begin
          free_slot[slot] = pos;
          class_fill[slot]--;
        end
      end
    end
    res.total_length = TOTAL_W'(class_fill[0] + class_fill[1] + class_fill[2]);
    return res;
  endfunction

  function automatic void check_field(input string name, input longint unsigned expected,
                                      input longint unsigned actual);
    if (expected != actual) begin
      $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
      fail_count++;
    end
  endfunction

  // Results are matched first, so a request taken on the same edge queues behind them.
  always @(posedge clk) begin
    queue_result_t want;
    if (!rst_n) begin
      for (int s = 0; s < NUM_CLASSES; s++) begin
        oldest_slot[s] = 0;
        free_slot[s]   = 0;
        class_fill[s]  = 0;
      end
      awaited_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result with no request outstanding: status %0d", out_status);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("out_status", want.status, out_status);
          check_field("out_item_date", want.item_date, out_item_date);
          check_field("out_item_code", want.item_code, out_item_code);
          check_field("out_item_class", want.item_class, out_item_class);
          check_field("out_total_length", want.total_length, out_total_length);
        end
      end
      if (in_valid && !in_stall) begin
        awaited_results.push_back(serve_request(req_type_t'(in_req_type), in_entry_date,
                                                in_entry_code, in_entry_class));
      end
    end
    pending = awaited_results.size();
  end

endmodule

>>> tb/sv/tb_top.sv
// Top of the priority queue testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import tcpq_pkg::*;

  localparam int TOTAL_ITEMS    = 1900;
  localparam int QUIET_ITEMS    = 200;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DATE_MAX       = 99991231;
  localparam int CODE_MAX       = 65535;

  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIX
  } traffic_mode_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [REQ_W-1:0]    in_req_type;
  logic [DATE_W-1:0]   in_entry_date;
  logic [CODE_W-1:0]   in_entry_code;
  logic [CLASS_W-1:0]  in_entry_class;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] out_status;
  logic [DATE_W-1:0]   out_item_date;
  logic [CODE_W-1:0]   out_item_code;
  logic [CLASS_W-1:0]  out_item_class;
  logic [TOTAL_W-1:0]  out_total_length;

  int fail_count;
  int pending;
  int sent_count;
  int in_gap_pct;
  bit quiet_tail;

  three_class_priority_queue_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_entry_date    (in_entry_date),
    .in_entry_code    (in_entry_code),
    .in_entry_class   (in_entry_class),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_item_date    (out_item_date),
    .out_item_code    (out_item_code),
    .out_item_class   (out_item_class),
    .out_total_length (out_total_length)
  );

  queue_result_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_entry_date    (in_entry_date),
    .in_entry_code    (in_entry_code),
    .in_entry_class   (in_entry_class),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_item_date    (out_item_date),
    .out_item_code    (out_item_code),
    .out_item_class   (out_item_class),
    .out_total_length (out_total_length),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Dates lean toward the edges of the range and patterns that flip every bit.
  function automatic logic [DATE_W-1:0] pick_date();
    logic [DATE_W-1:0] date;
    case ($urandom_range(0, 9))
      0: date = '0;
      1: date = DATE_W'(DATE_MAX);
      2: date = DATE_W'(32'h3FF_FFFF);
      default: date = DATE_W'($urandom_range(0, DATE_MAX));
    endcase
    return date;
  endfunction

  // Present one request at the falling edge and hold it until the queue takes it.
  task automatic send_request(input req_type_t kind, input logic [DATE_W-1:0] date,
                              input logic [CODE_W-1:0] code, input logic [CLASS_W-1:0] cls);
    in_valid       <= 1'b1;
    in_req_type    <= kind;
    in_entry_date  <= date;
    in_entry_code  <= code;
    in_entry_class <= cls;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    @(negedge clk);
    sent_count++;
    if (!quiet_tail && $urandom_range(1, 100) <= in_gap_pct) begin
      in_valid       <= 1'b0;
      in_req_type    <= REQ_INSERT;
      in_entry_date  <= pick_date();
      in_entry_code  <= CODE_W'($urandom_range(0, CODE_MAX));
      in_entry_class <= CLASS_W'($urandom_range(0, 3));
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  // Result side: stall bursts between free stretches of varying length.
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8))
        @(negedge clk);
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when no request or result moves for too long.
  initial begin
    int stuck_cycles;
    stuck_cycles = 0;
    while (stuck_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall))) begin
        stuck_cycles++;
      end else begin
        stuck_cycles = 0;
      end
    end
    $display("status: fail");
    $finish;
  end

  // Stimulus: reset, directed requests, then traffic in fill, drain and mixed segments.
  initial begin
    traffic_mode_t mode;
    int seg_len;
    int insert_pct;
    int favored;
    req_type_t kind;
    logic [CLASS_W-1:0] cls;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req_type    = REQ_INSERT;
    in_entry_date  = '0;
    in_entry_code  = '0;
    in_entry_class = '0;
    sent_count     = 0;
    quiet_tail     = 1'b0;
    in_gap_pct     = 20;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Every read and removal on an empty queue.
    send_request(REQ_READ_HEAD, pick_date(), 16'hFFFF, 2'd3);
    send_request(REQ_REMOVE_HEAD, pick_date(), 16'h0000, 2'd0);
    send_request(REQ_REMOVE_TAIL, pick_date(), 16'h5A5A, 2'd2);
    // Inserts for every class value, with the field extremes and alternating bit patterns.
    send_request(REQ_INSERT, '0, 16'h0000, 2'd0);
    send_request(REQ_INSERT, DATE_W'(DATE_MAX), 16'hFFFF, 2'd1);
    send_request(REQ_INSERT, DATE_W'(32'h3FF_FFFF), 16'hAAAA, ENTRY_CLASS_MID);
    send_request(REQ_INSERT, DATE_W'(32'h2AA_AAAA), 16'h5555, ENTRY_CLASS_TOP);
    send_request(REQ_INSERT, DATE_W'(12345678), 16'h1234, ENTRY_CLASS_MID);
    // Head comes from the top class, tails from the ordinary class first.
    send_request(REQ_READ_HEAD, '0, '0, '0);
    send_request(REQ_REMOVE_TAIL, '0, '0, '0);
    send_request(REQ_REMOVE_TAIL, '0, '0, '0);
    send_request(REQ_REMOVE_TAIL, '0, '0, '0);
    send_request(REQ_READ_HEAD, '0, '0, '0);
    send_request(REQ_REMOVE_HEAD, '0, '0, '0);
    send_request(REQ_READ_HEAD, '0, '0, '0);
    send_request(REQ_REMOVE_HEAD, '0, '0, '0);
    send_request(REQ_REMOVE_HEAD, '0, '0, '0);
    // A lone top-class entry is both head and tail.
    send_request(REQ_INSERT, DATE_W'(20240229), 16'h8001, ENTRY_CLASS_TOP);
    send_request(REQ_REMOVE_TAIL, '0, '0, '0);
    send_request(REQ_REMOVE_TAIL, '0, '0, '0);

    while (sent_count < TOTAL_ITEMS) begin
      seg_len    = $urandom_range(60, 160);
      mode       = traffic_mode_t'($urandom_range(0, 2));
      favored    = $urandom_range(0, 3);
      in_gap_pct = ($urandom_range(0, 1) == 0) ? 0 : 25;
      insert_pct = (mode == MODE_FILL) ? 90 : (mode == MODE_DRAIN) ? 15 : 50;
      repeat (seg_len) begin
        if ($urandom_range(1, 100) <= insert_pct) begin
          kind = REQ_INSERT;
        end else begin
          kind = req_type_t'($urandom_range(1, 3));
        end
        // Fill segments pile into one class so that it runs full.
        if (mode == MODE_FILL && $urandom_range(1, 100) <= 80) begin
          cls = CLASS_W'(favored);
        end else begin
          cls = CLASS_W'($urandom_range(0, 3));
        end
        send_request(kind, pick_date(), CODE_W'($urandom_range(0, CODE_MAX)), cls);
        if (sent_count >= TOTAL_ITEMS - QUIET_ITEMS) begin
          quiet_tail = 1'b1;
        end
      end
    end
    in_valid <= 1'b0;

    // Drain the outstanding results, then check once more that none are left.
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
    if (pending != 0) begin
      $error("%0d results never arrived", pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
